>>> rtl/sorted_record_table_macros.svh
// assertion helpers for the sorted record table
`ifndef SORTED_RECORD_TABLE_MACROS_SVH
`define SORTED_RECORD_TABLE_MACROS_SVH

// same-cycle implication
`define SRT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sorted_record_table: check failed");

// next-cycle implication
`define SRT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sorted_record_table: check failed");

`endif

>>> rtl/srt_pkg.sv
package srt_pkg;

    localparam int SRT_DEPTH = 32;
    localparam int MAX_OUT   = 32;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_SEARCH = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_COUNT  = 3'd3,
        ACT_DUMP   = 3'd4,
        ACT_CLEAR  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] key;
        logic [15:0]        grade;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] found_key;
        logic [15:0]        found_grade;
        logic [4:0]         position;
        logic [5:0]         occupancy;
        logic               last;
    } out_item_t;

    typedef enum logic [2:0] {
        CELL_IDLE   = 3'd0,
        CELL_LOOKUP = 3'd1,
        CELL_INSERT = 3'd2,
        CELL_DELETE = 3'd3,
        CELL_ROTATE = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic signed [31:0] key;
        logic [15:0]        grade;
    } cell_ctrl_t;

    typedef struct packed {
        logic le;
        logic eq;
        logic hit;
    } cell_stat_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [15:0]        grade;
        logic [4:0]         pos;
    } cell_sel_t;

endpackage

>>> rtl/srt_cell.sv
module srt_cell import srt_pkg::*; #(
    parameter int INDEX = 0,
    parameter int CNT_W = 6
) (
    input  logic               aclk,
    input  cell_ctrl_t         ctrl,
    input  logic [CNT_W-1:0]   count,
    input  logic signed [31:0] left_key,
    input  logic [15:0]        left_grade,
    input  logic               left_le,
    input  logic               left_eq,
    input  logic signed [31:0] right_key,
    input  logic [15:0]        right_grade,
    input  logic signed [31:0] head_key,
    input  logic [15:0]        head_grade,
    output logic signed [31:0] key,
    output logic [15:0]        grade,
    output cell_stat_t         stat,
    output cell_sel_t          sel
);

    localparam logic [CNT_W-1:0] IDX  = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX1 = CNT_W'(INDEX + 1);

    logic signed [31:0] key_reg, key_next;
    logic [15:0]        grade_reg, grade_next;
    logic               occ, le, lt, eq, hit;

    assign occ = IDX < count;
    assign le  = occ && (key_reg <= ctrl.key);
    assign lt  = occ && (key_reg < ctrl.key);
    assign eq  = occ && (key_reg == ctrl.key);

    always_comb begin
        case (ctrl.op)
            CELL_INSERT: hit = !le && left_le;
            CELL_LOOKUP: hit = eq && !left_eq;
            default:     hit = 1'b0;
        endcase
    end

    always_comb begin
        key_next   = key_reg;
        grade_next = grade_reg;
        case (ctrl.op)
            CELL_INSERT: begin
                if (!le && left_le) begin
                    key_next   = ctrl.key;
                    grade_next = ctrl.grade;
                end else if (!le) begin
                    key_next   = left_key;
                    grade_next = left_grade;
                end
            end
            CELL_DELETE: begin
                if (!lt) begin
                    key_next   = right_key;
                    grade_next = right_grade;
                end
            end
            CELL_ROTATE: begin
                if (IDX1 == count) begin
                    key_next   = head_key;
                    grade_next = head_grade;
                end else if (IDX1 < count) begin
                    key_next   = right_key;
                    grade_next = right_grade;
                end
            end
            default: begin
                key_next   = key_reg;
                grade_next = grade_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        grade_reg <= grade_next;
    end

    assign key       = key_reg;
    assign grade     = grade_reg;
    assign stat.le   = le;
    assign stat.eq   = eq;
    assign stat.hit  = hit;
    assign sel.key   = hit ? key_reg : '0;
    assign sel.grade = hit ? grade_reg : '0;
    assign sel.pos   = hit ? 5'(INDEX) : '0;

endmodule

>>> rtl/sorted_record_table.sv
// Sorted record table: holds up to DEPTH records (signed 32-bit key, Q8.8 grade) in ascending
// key order in a row of cells, one record per cell. Each cell compares its own key with the
// command key and shifts with its neighbors. For every operation but dump the command is
// registered, then the cells act on it and the result is registered and offered; a delete
// makes a lookup pass, then a shift pass. Dump rotates the row through cell 0 one record per
// cycle while the output is not stalled, offering one result per record, up to MAX_OUT; the
// row is back in order when it ends. Only one item is in flight: s_ready rises only after the
// last result of the item has been transferred.
`include "sorted_record_table_macros.svh"

module sorted_record_table import srt_pkg::*; #(
    parameter int DEPTH = SRT_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_DUMP  = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    in_item_t         cmd_reg, cmd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    out_item_t        out_reg, out_next;
    logic             m_valid_reg, m_valid_next;

    cell_ctrl_t         ctrl;
    logic signed [31:0] cell_key   [DEPTH];
    logic [15:0]        cell_grade [DEPTH];
    cell_stat_t         cell_stat  [DEPTH];
    cell_sel_t          cell_sel   [DEPTH];
    logic [DEPTH-1:0]   hit_vec;
    cell_sel_t          sel;

    logic empty, full, emit, dump_step, dump_last;

    assign empty = count_reg == '0;
    assign full  = count_reg == CNT_W'(DEPTH);
    assign emit  = int'(idx_reg) < MAX_OUT;
    assign dump_last = (int'(idx_reg) + 1 == int'(count_reg)) || (int'(idx_reg) + 1 == MAX_OUT);
    assign dump_step = (state_reg == ST_DUMP) && (!emit || !m_valid_reg || m_ready);

    always_comb begin
        ctrl.op    = CELL_IDLE;
        ctrl.key   = cmd_reg.key;
        ctrl.grade = cmd_reg.grade;
        case (state_reg)
            ST_EXEC: begin
                if (cmd_reg.action == ACT_INSERT && !full) begin
                    ctrl.op = CELL_INSERT;
                end else if (cmd_reg.action == ACT_SEARCH || cmd_reg.action == ACT_DELETE) begin
                    ctrl.op = CELL_LOOKUP;
                end
            end
            ST_SHIFT: ctrl.op = CELL_DELETE;
            ST_DUMP:  ctrl.op = dump_step ? CELL_ROTATE : CELL_IDLE;
            default:  ctrl.op = CELL_IDLE;
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [31:0] lkey, rkey;
        logic [15:0]        lgrade, rgrade;
        logic               lle, leq;

        if (i == 0) begin : g_head
            assign lkey   = '0;
            assign lgrade = '0;
            assign lle    = 1'b1;
            assign leq    = 1'b0;
        end else begin : g_body
            assign lkey   = cell_key[i-1];
            assign lgrade = cell_grade[i-1];
            assign lle    = cell_stat[i-1].le;
            assign leq    = cell_stat[i-1].eq;
        end

        if (i == DEPTH - 1) begin : g_tail
            assign rkey   = '0;
            assign rgrade = '0;
        end else begin : g_inner
            assign rkey   = cell_key[i+1];
            assign rgrade = cell_grade[i+1];
        end

        srt_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_key    (lkey),
            .left_grade  (lgrade),
            .left_le     (lle),
            .left_eq     (leq),
            .right_key   (rkey),
            .right_grade (rgrade),
            .head_key    (cell_key[0]),
            .head_grade  (cell_grade[0]),
            .key         (cell_key[i]),
            .grade       (cell_grade[i]),
            .stat        (cell_stat[i]),
            .sel         (cell_sel[i])
        );

        assign hit_vec[i] = cell_stat[i].hit;
    end

    // at most one cell reports, so an or across the row selects it
    always_comb begin
        sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel.key   = sel.key | cell_sel[i].key;
            sel.grade = sel.grade | cell_sel[i].grade;
            sel.pos   = sel.pos | cell_sel[i].pos;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next = s_data;
                    if (s_data.action <= ACT_CLEAR) begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                out_next           = '0;
                out_next.last      = 1'b1;
                out_next.occupancy = 6'(count_reg);
                m_valid_next       = 1'b1;
                state_next         = ST_RESP;
                case (cmd_reg.action)
                    ACT_INSERT: begin
                        if (full) begin
                            out_next.status = STAT_FULL;
                        end else begin
                            out_next.status      = STAT_OK;
                            out_next.found_key   = cmd_reg.key;
                            out_next.found_grade = cmd_reg.grade;
                            out_next.position    = sel.pos;
                            out_next.occupancy   = 6'(count_reg + 1'b1);
                            count_next           = count_reg + 1'b1;
                        end
                    end
                    ACT_SEARCH, ACT_DELETE: begin
                        if (empty) begin
                            out_next.status = STAT_EMPTY;
                        end else if (hit_vec == '0) begin
                            out_next.status = STAT_NOT_FOUND;
                        end else begin
                            out_next.status      = STAT_OK;
                            out_next.found_key   = sel.key;
                            out_next.found_grade = sel.grade;
                            out_next.position    = sel.pos;
                            if (cmd_reg.action == ACT_DELETE) begin
                                out_next.occupancy = 6'(count_reg - 1'b1);
                                state_next         = ST_SHIFT;
                            end
                        end
                    end
                    ACT_COUNT: begin
                        out_next.status = empty ? STAT_EMPTY : STAT_OK;
                    end
                    ACT_DUMP: begin
                        if (empty) begin
                            out_next.status = STAT_EMPTY;
                        end else begin
                            out_next     = out_reg;
                            m_valid_next = 1'b0;
                            idx_next     = '0;
                            state_next   = ST_DUMP;
                        end
                    end
                    ACT_CLEAR: begin
                        out_next.status    = empty ? STAT_EMPTY : STAT_OK;
                        out_next.occupancy = '0;
                        count_next         = '0;
                    end
                    default: begin
                        m_valid_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                endcase
            end
            ST_SHIFT: begin
                count_next = count_reg - 1'b1;
                state_next = ST_RESP;
            end
            ST_DUMP: begin
                if (dump_step) begin
                    if (emit) begin
                        out_next.status      = STAT_OK;
                        out_next.found_key   = cell_key[0];
                        out_next.found_grade = cell_grade[0];
                        out_next.position    = 5'(idx_reg);
                        out_next.occupancy   = 6'(count_reg);
                        out_next.last        = dump_last;
                        m_valid_next         = 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == count_reg) begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `SRT_ASSERT_NOW(a_count_range, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `SRT_ASSERT_NOW(a_insert_one_slot, aclk, aresetn, ctrl.op == CELL_INSERT, $onehot(hit_vec))
    `SRT_ASSERT_NOW(a_lookup_first, aclk, aresetn, ctrl.op == CELL_LOOKUP, $onehot0(hit_vec))
    `SRT_ASSERT_NEXT(a_delete_count, aclk, aresetn, state_reg == ST_SHIFT,
        count_reg == $past(count_reg) - 1'b1)

endmodule
